@@ src/full_length_correlation_engine_defines.svh @@
// Assertion macros used by the correlation engine back end
`ifndef FULL_LENGTH_CORRELATION_ENGINE_DEFINES_SVH
`define FULL_LENGTH_CORRELATION_ENGINE_DEFINES_SVH

// Property that must hold on every clock edge outside reset
`define FCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset
`define FCE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/fce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fce_pkg;

  localparam int unsigned MAX_TAPS          = 256;
  localparam int unsigned TAP_COUNT_W       = 9;
  localparam int unsigned TAP_COUNT_RESET   = 1;
  localparam int unsigned IDX_W             = 8;
  localparam int unsigned DATA_W            = 16;
  localparam int unsigned PROD_W            = 2 * DATA_W;
  localparam int unsigned RESULT_W          = 40;
  localparam int unsigned S_TDATA_W         = 24;
  localparam int unsigned M_TDATA_W         = 40;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } fce_op_e;

  typedef struct packed {
    fce_op_e                  op;
    logic [IDX_W-1:0]         tap_index;
    logic signed [DATA_W-1:0] value;
  } fce_cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic     valid;
    fce_cmd_t cmd;
  } fce_q_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } fce_state_e;

endpackage

`default_nettype wire

@@ src/fce_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fce_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/fce_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fce_front import fce_pkg::*; #(
  parameter int unsigned MaxTaps = MAX_TAPS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // tap_index[7:0], value[23:8]
  input  wire logic                 s_axis_tuser,  // operation[0]
  output fce_q_t                    q_o,
  input  wire logic                 pop_i
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  fce_cmd_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  fce_cmd_t           cmd;
  logic               accept, keep, push;

  assign cmd.op        = fce_op_e'(s_axis_tuser);
  assign cmd.tap_index = s_axis_tdata[IDX_W-1:0];
  assign cmd.value     = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];

  // out-of-range tap loads are dropped here
  assign keep   = (cmd.op == OP_SAMPLE) || (32'(cmd.tap_index) < MaxTaps);
  assign s_axis_tready = (cnt_q != QCntW'(QDepth));
  assign accept = s_axis_tvalid && s_axis_tready;
  assign push   = accept && keep;

  assign q_o.valid = (cnt_q != '0);
  assign q_o.cmd   = mem_q[rd_q];

  always_comb begin
    wr_d  = push  ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPtrW'(1) : rd_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

@@ src/fce_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "full_length_correlation_engine_defines.svh"

module fce_back import fce_pkg::*; #(
  parameter int unsigned MaxTaps = MAX_TAPS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [TAP_COUNT_W-1:0] tap_count_i,
  input  wire fce_q_t                 q_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [M_TDATA_W-1:0]   m_axis_tdata   // result[39:0]
);

  localparam int unsigned AW = $clog2(MaxTaps);
  localparam int unsigned CW = $clog2(MaxTaps + 1);
  localparam int unsigned MW = (CW > TAP_COUNT_W) ? CW : TAP_COUNT_W;

  fce_state_e                  state_q, state_d;
  logic [AW-1:0]               wp_q, wp_d, wp_next;
  logic [CW-1:0]               fill_q, fill_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               haddr_q, haddr_d, taddr_q, taddr_d;
  logic signed [RESULT_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0]    prod_q;
  logic                        p1_valid_q, p1_zero_q, p1_last_q;
  logic                        p2_valid_q, p2_last_q;
  logic                        out_valid_q, out_valid_d;
  logic [RESULT_W-1:0]         out_data_q, out_data_d;
  logic [MW-1:0]               tc_ext;
  logic [CW-1:0]               taps_m;
  logic                        issue, last_issue, take_load, take_sample, out_free;
  logic [DATA_W-1:0]           h_rdata, t_rdata;
  logic signed [DATA_W-1:0]    h_op;

  assign tc_ext = MW'(tap_count_i);
  assign taps_m = (tc_ext > MW'(MaxTaps)) ? CW'(MaxTaps) : CW'(tc_ext);

  assign pop_o       = (state_q == S_IDLE) && q_i.valid;
  assign take_load   = pop_o && (q_i.cmd.op == OP_LOAD);
  assign take_sample = pop_o && (q_i.cmd.op == OP_SAMPLE);
  assign wp_next     = (wp_q == AW'(MaxTaps - 1)) ? '0 : wp_q + AW'(1);
  assign issue       = (state_q == S_RUN);
  assign last_issue  = (cnt_q == taps_m - CW'(1));
  assign out_free    = !out_valid_q || m_axis_tready;

  fce_ram #(.Width(DATA_W), .Depth(MaxTaps)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (take_load),
    .waddr_i (AW'(q_i.cmd.tap_index)),
    .wdata_i (q_i.cmd.value),
    .raddr_i (taddr_q),
    .rdata_o (t_rdata)
  );

  // circular history, newest sample at wp_q
  fce_ram #(.Width(DATA_W), .Depth(MaxTaps)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (take_sample),
    .waddr_i (wp_next),
    .wdata_i (q_i.cmd.value),
    .raddr_i (haddr_q),
    .rdata_o (h_rdata)
  );

  // entries older than the fill count are read as zeros
  assign h_op = p1_zero_q ? '0 : signed'(h_rdata);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    haddr_d     = haddr_q;
    taddr_d     = taddr_q;
    acc_d       = p2_valid_q ? acc_q + {{(RESULT_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} : acc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (take_sample) begin
          wp_d    = wp_next;
          fill_d  = (fill_q == CW'(MaxTaps)) ? fill_q : fill_q + CW'(1);
          haddr_d = wp_next;
          taddr_d = AW'(taps_m - CW'(1));
          cnt_d   = '0;
          acc_d   = '0;
          state_d = (taps_m == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        haddr_d = (haddr_q == '0) ? AW'(MaxTaps - 1) : haddr_q - AW'(1);
        taddr_d = taddr_q - AW'(1);
        cnt_d   = cnt_q + CW'(1);
        if (last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (p2_valid_q && p2_last_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= AW'(MaxTaps - 1);
      fill_q      <= '0;
      cnt_q       <= '0;
      p1_valid_q  <= 1'b0;
      p1_last_q   <= 1'b0;
      p2_valid_q  <= 1'b0;
      p2_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      p1_valid_q  <= issue;
      p1_last_q   <= issue && last_issue;
      p2_valid_q  <= p1_valid_q;
      p2_last_q   <= p1_valid_q && p1_last_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    haddr_q    <= haddr_d;
    taddr_q    <= taddr_d;
    acc_q      <= acc_d;
    p1_zero_q  <= (cnt_q >= fill_q);
    prod_q     <= h_op * signed'(t_rdata);
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `FCE_ASSERT(a_last_ends_sum, p2_valid_q && p2_last_q |=> state_q == S_DONE, "sum not closed")
  `FCE_NEVER(a_pipe_idle, (p1_valid_q || p2_valid_q) && (state_q == S_IDLE || state_q == S_DONE), "MAC pipe busy outside a sum")
  `FCE_NEVER(a_fill_bound, fill_q > CW'(MaxTaps), "history fill count past depth")
  `FCE_ASSERT(a_result_load, $rose(out_valid_q) |-> $past(state_q) == S_DONE, "result loaded outside done state")

endmodule

`default_nettype wire

@@ src/full_length_correlation_engine.sv @@
// Load transaction: written to the tap RAM as it is popped from the queue head.
// Sample transaction: queue head to result register by one multiply-accumulate per tap
//   over the tap and history RAM read ports, via product and accumulate registers.
// Zero taps in use: result is zero. Front queue registers each command.
// Reset: tap count back to 1, history reads as zeros, queue and result valid cleared;
//   tap RAM contents stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module full_length_correlation_engine import fce_pkg::*; #(
  parameter int unsigned MaxTaps = MAX_TAPS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [TAP_COUNT_W-1:0] cfg_wdata_i,   // tap_count[8:0]
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,  // tap_index[7:0], value[23:8]
  input  wire logic                   s_axis_tuser,  // operation[0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [M_TDATA_W-1:0]   m_axis_tdata   // result[39:0]
);

  logic [TAP_COUNT_W-1:0] tap_count_q;
  fce_q_t                 q_head;
  logic                   q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_W'(TAP_COUNT_RESET);
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  fce_front #(.MaxTaps(MaxTaps)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_o           (q_head),
    .pop_i         (q_pop)
  );

  fce_back #(.MaxTaps(MaxTaps)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tap_count_i   (tap_count_q),
    .q_i           (q_head),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ dv/full_length_correlation_engine_tb.sv @@
`timescale 1ns / 1ps

module full_length_correlation_engine_tb;
  import fce_pkg::*;

  class corr_tracker;
    logic signed [DATA_W-1:0] taps [MAX_TAPS];
    logic signed [DATA_W-1:0] hist [MAX_TAPS];
    logic [TAP_COUNT_W-1:0]   taps_in_use;
    logic [RESULT_W-1:0]      sums_due [$];
    int unsigned              errors;

    function new();
      foreach (taps[i]) begin
        taps[i] = '0;
        hist[i] = '0;
      end
      taps_in_use = TAP_COUNT_W'(TAP_COUNT_RESET);
      errors = 0;
    endfunction

    function void set_taps_in_use(logic [TAP_COUNT_W-1:0] v);
      taps_in_use = v;
    endfunction

    function void take_cmd(fce_cmd_t c);
      int unsigned span;
      longint acc;
      if (c.op == OP_LOAD) begin
        taps[c.tap_index] = c.value;
        return;
      end
      for (int i = MAX_TAPS - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = c.value;
      span = (taps_in_use > MAX_TAPS) ? MAX_TAPS : taps_in_use;
      acc = 0;
      for (int i = 0; i < span; i++) begin
        acc += longint'(hist[i]) * longint'(taps[span-1-i]);
      end
      sums_due.push_back(acc[RESULT_W-1:0]);
    endfunction

    function void match_sum(logic [RESULT_W-1:0] got);
      logic [RESULT_W-1:0] want;
      if (sums_due.size() == 0) begin
        $error("result: expected none, got %0d", $signed(got));
        errors++;
        return;
      end
      want = sums_due.pop_front();
      if (got !== want) begin
        $error("result: expected %0d, got %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [TAP_COUNT_W-1:0] cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  corr_tracker sums;
  bit          tap_loaded [MAX_TAPS];
  bit          hold_req;
  bit          src_steady;
  bit          sink_steady;
  int unsigned items_sent;

  full_length_correlation_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 19))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  function automatic int first_unloaded(int unsigned span);
    for (int i = 0; i < span; i++) begin
      if (!tap_loaded[i]) return i;
    end
    return -1;
  endfunction

  task automatic push_cmd(input fce_cmd_t c);
    int unsigned g;
    g = src_steady ? 0 : pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.value, c.tap_index};
    s_axis_tuser  <= c.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sums.take_cmd(c);
    items_sent++;
  endtask

  task automatic load_tap(input int unsigned idx, input logic signed [DATA_W-1:0] v);
    fce_cmd_t c;
    c.op        = OP_LOAD;
    c.tap_index = idx[IDX_W-1:0];
    c.value     = v;
    tap_loaded[idx] = 1'b1;
    push_cmd(c);
  endtask

  task automatic push_sample(input logic signed [DATA_W-1:0] v);
    fce_cmd_t c;
    c.op        = OP_SAMPLE;
    c.tap_index = IDX_W'($urandom());
    c.value     = v;
    push_cmd(c);
  endtask

  // block must be idle, incl. trailing loads, before a register write
  task automatic set_tap_count(input logic [TAP_COUNT_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sums.sums_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sums.set_taps_in_use(v);
  endtask

  initial begin
    int unsigned plan [7];
    int unsigned m;
    int unsigned span;
    int unsigned quota;
    int unsigned done_in_phase;
    int unsigned ph;
    int          hole;

    sums = new();
    plan = '{3, 16, 256, 1, 511, 7, 64};
    items_sent  = 0;
    hold_req    = 1'b0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    foreach (tap_loaded[i]) tap_loaded[i] = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one tap after reset
    load_tap(0, 16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'sh0001);
    push_sample(16'shffff);
    load_tap(0, 16'sh8000);
    push_sample(16'sh8000);
    push_sample(16'sh7fff);
    load_tap(255, 16'sh8000);
    load_tap(1, 16'sh7fff);

    set_tap_count(9'd2);
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh8000);

    // no taps in use
    set_tap_count(9'd0);
    push_sample(16'sh3039);
    push_sample(16'sh8000);

    ph = 0;
    while (items_sent < 550) begin
      m = (ph < 7) ? plan[ph] : $urandom_range(1, 24);
      set_tap_count(m[TAP_COUNT_W-1:0]);
      span  = (m > MAX_TAPS) ? MAX_TAPS : m;
      quota = (span > 32) ? 20 : 60;
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        src_steady  = 1'b1;
        sink_steady = 1'b0;
        hold_req    = 1'b1;
      end
      done_in_phase = 0;
      while (done_in_phase < quota) begin
        hole = first_unloaded(span);
        if (hole >= 0) begin
          load_tap(hole, rand_word());
        end else begin
          if ($urandom_range(0, 99) < 60) push_sample(rand_word());
          else load_tap($urandom_range(0, MAX_TAPS - 1), rand_word());
          done_in_phase++;
        end
      end
      ph++;
    end

    s_axis_tvalid <= 1'b0;
    while (sums.sums_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sums.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sums.match_sum(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 399;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = sink_steady ? 0 : pick_gap();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
